// ===== hw/rtl/cspw_pkg.sv =====
// Shared types and constants of the clipped span pixel writer.
package cspw_pkg;

    // Configuration register indexes
    localparam logic [1:0] REG_BASE_ADDRESS = 2'd0;
    localparam logic [1:0] REG_H_RES        = 2'd1;
    localparam logic [1:0] REG_V_RES        = 2'd2;
    localparam logic [1:0] REG_PIXEL_FORMAT = 2'd3;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;
    localparam int RES_W       = 13;

    // Pixel format codes; the size code of a write equals the format code
    localparam logic [1:0] FMT_8BPP  = 2'd0;
    localparam logic [1:0] FMT_16BPP = 2'd1;
    localparam logic [1:0] FMT_32BPP = 2'd2;
    localparam logic [1:0] FMT_NONE  = 2'd3;

    // Span modes
    localparam logic MODE_FILL  = 1'b0;
    localparam logic MODE_GLYPH = 1'b1;

    // Reset values of the configuration registers
    localparam logic [31:0]      BASE_RESET = 32'd0;
    localparam logic [RES_W-1:0] H_RES_RESET = 13'd800;
    localparam logic [RES_W-1:0] V_RES_RESET = 13'd480;
    localparam logic [1:0]       FMT_RESET   = FMT_16BPP;

    // Configuration bundle seen by the front end
    typedef struct packed {
        logic [31:0]      base_address;
        logic [RES_W-1:0] h_res;
        logic [RES_W-1:0] v_res;
        logic [1:0]       pixel_format;
    } cspw_cfg_t;

    // One classified span as it travels to the back end
    typedef struct packed {
        logic [31:0] addr;
        logic [31:0] data;
        logic [1:0]  size;
    } cspw_job_t;

endpackage

// ===== hw/rtl/clipped_span_pixel_writer.sv =====
// Top level of the clipped span pixel writer: configuration registers and wiring.
//
// A span is taken when start is high and busy is low; busy stays high while the
// front end clips the span and forms its first address, and longer while the
// queue is full. The span then waits in a two-entry queue until the back end is
// free. The back end loads the span and then walks it pixel by pixel up to the
// last pixel that is drawn, at most SPAN_MAX pixels and at most one write per
// cycle; it takes the next span only once that walk is done. Each write appears
// on the write ports for exactly one cycle with write_strobe high and cannot be
// held off by the receiver; last marks the final write of a span. Spans that
// draw nothing produce no write.
module clipped_span_pixel_writer #(
    parameter int SPAN_MAX   = 64,
    parameter int COORD_BITS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [cspw_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [cspw_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                           start,
    output logic                           busy,
    input  logic                           mode,
    input  logic [15:0]                    row_x,
    input  logic [15:0]                    row_y,
    input  logic [6:0]                     span_width,
    input  logic [31:0]                    color,
    input  logic [63:0]                    pixel_mask,
    output logic                           write_strobe,
    output logic [31:0]                    write_address,
    output logic [31:0]                    write_data,
    output logic [1:0]                     write_size,
    output logic                           last
);
    import cspw_pkg::*;

    localparam int QW = $bits(cspw_job_t) + SPAN_MAX;

    logic [31:0]      base_reg;
    logic [RES_W-1:0] h_res_reg;
    logic [RES_W-1:0] v_res_reg;
    logic [1:0]       fmt_reg;
    cspw_cfg_t        cfg;

    logic                q_push;
    logic                q_full;
    logic                q_pop;
    logic                q_empty;
    cspw_job_t           push_job;
    logic [SPAN_MAX-1:0] push_vec;
    cspw_job_t           pop_job;
    logic [SPAN_MAX-1:0] pop_vec;
    logic [QW-1:0]       pop_word;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg  <= BASE_RESET;
            h_res_reg <= H_RES_RESET;
            v_res_reg <= V_RES_RESET;
            fmt_reg   <= FMT_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_BASE_ADDRESS: base_reg  <= cfg_data;
                REG_H_RES:        h_res_reg <= cfg_data[RES_W-1:0];
                REG_V_RES:        v_res_reg <= cfg_data[RES_W-1:0];
                REG_PIXEL_FORMAT: fmt_reg   <= cfg_data[1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        cfg.base_address = base_reg;
        cfg.h_res        = h_res_reg;
        cfg.v_res        = v_res_reg;
        cfg.pixel_format = fmt_reg;
    end

    cspw_front #(
        .SPAN_MAX   (SPAN_MAX),
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .start      (start),
        .busy       (busy),
        .mode       (mode),
        .row_x      (row_x),
        .row_y      (row_y),
        .span_width (span_width),
        .color      (color),
        .pixel_mask (pixel_mask),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_job      (push_job),
        .q_vec      (push_vec)
    );

    cspw_queue #(
        .W     (QW),
        .DEPTH (2)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data ({push_job, push_vec}),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (pop_word),
        .empty     (q_empty)
    );

    assign pop_job = pop_word[QW-1:SPAN_MAX];
    assign pop_vec = pop_word[SPAN_MAX-1:0];

    cspw_back #(
        .SPAN_MAX (SPAN_MAX)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_empty),
        .q_job         (pop_job),
        .q_vec         (pop_vec),
        .q_pop         (q_pop),
        .write_strobe  (write_strobe),
        .write_address (write_address),
        .write_data    (write_data),
        .write_size    (write_size),
        .last          (last)
    );

endmodule

// ===== hw/rtl/cspw_front.sv =====
// Front end: accepts a span, clips it and works out its first address.
module cspw_front #(
    parameter int SPAN_MAX   = 64,
    parameter int COORD_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  cspw_pkg::cspw_cfg_t   cfg,
    input  logic                  start,
    output logic                  busy,
    input  logic                  mode,
    input  logic [15:0]           row_x,
    input  logic [15:0]           row_y,
    input  logic [6:0]            span_width,
    input  logic [31:0]           color,
    input  logic [63:0]           pixel_mask,
    input  logic                  q_full,
    output logic                  q_push,
    output cspw_pkg::cspw_job_t   q_job,
    output logic [SPAN_MAX-1:0]   q_vec
);
    import cspw_pkg::*;

    localparam int CW    = $clog2(SPAN_MAX + 1);
    localparam int DW    = ((COORD_BITS > RES_W) ? COORD_BITS : RES_W) + 2;
    localparam int PW    = COORD_BITS - 1 + RES_W;

    typedef enum logic [1:0] {
        F_IDLE,
        F_CALC,
        F_PUSH
    } front_state_t;

    front_state_t              state_reg, state_next;
    logic                      mode_reg;
    logic [COORD_BITS-1:0]     x_reg;
    logic [COORD_BITS-1:0]     y_reg;
    logic [6:0]                width_reg;
    logic [31:0]               color_reg;
    logic [SPAN_MAX-1:0]       mask_reg;
    logic [PW-1:0]             prod_reg;
    logic [SPAN_MAX-1:0]       vec_reg, vec_next;
    logic [31:0]               data_reg;

    logic signed [COORD_BITS-1:0] x0;
    logic                      y_ok;
    logic [CW-1:0]             w_sat;
    logic [CW-1:0]             lo;
    logic [CW-1:0]             hi;
    logic signed [DW-1:0]      neg_x;
    logic signed [DW-1:0]      room;
    logic [PW+1:0]             row_off;

    // Pack RGB888 into RGB565 or trim to the format
    function automatic logic [31:0] fmt_data(input logic [31:0] c, input logic [1:0] f);
        logic [31:0] r;
        begin
            case (f)
                FMT_8BPP:  r = {24'd0, c[7:0]};
                FMT_16BPP: r = {16'd0, c[23:19], c[15:10], c[7:3]};
                default:   r = c;
            endcase
            return r;
        end
    endfunction

    assign x0   = signed'(x_reg);
    assign y_ok = !y_reg[COORD_BITS-1] &&
                  ({{(DW-COORD_BITS){1'b0}}, y_reg} < DW'(cfg.v_res));

    // Saturate the width and clip both ends of the span
    always_comb
    begin
        if (width_reg > 7'(SPAN_MAX))
            w_sat = CW'(SPAN_MAX);
        else
            w_sat = CW'(width_reg);

        neg_x = -DW'(x0);
        if (!x0[COORD_BITS-1])
            lo = '0;
        else if (neg_x > DW'(SPAN_MAX))
            lo = CW'(SPAN_MAX);
        else
            lo = CW'(neg_x);

        room = DW'(signed'({1'b0, cfg.h_res})) - DW'(x0);
        if (room < 0)
            hi = '0;
        else if (room > DW'(signed'({1'b0, w_sat})))
            hi = w_sat;
        else
            hi = CW'(room);
    end

    // Mark the pixels that get a write
    always_comb
    begin
        for (int p = 0; p < SPAN_MAX; p++)
        begin
            vec_next[p] = (CW'(p) >= lo) && (CW'(p) < hi) &&
                          ((mode_reg == MODE_FILL) || mask_reg[p]);
        end
        if (!y_ok || (cfg.pixel_format == FMT_NONE))
            vec_next = '0;
    end

    // Step through capture, classify and hand-off
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (start)
                    state_next = F_CALC;
            end
            F_CALC:
            begin
                state_next = F_PUSH;
            end
            F_PUSH:
            begin
                if ((vec_reg == '0) || !q_full)
                    state_next = F_IDLE;
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Hold the item and the classified values
    always_ff @(posedge clk)
    begin
        if ((state_reg == F_IDLE) && start)
        begin
            mode_reg  <= mode;
            x_reg     <= row_x[COORD_BITS-1:0];
            y_reg     <= row_y[COORD_BITS-1:0];
            width_reg <= span_width;
            color_reg <= color;
            mask_reg  <= pixel_mask[SPAN_MAX-1:0];
        end
        if (state_reg == F_CALC)
        begin
            prod_reg <= PW'(y_reg[COORD_BITS-2:0]) * PW'(cfg.h_res);
            vec_reg  <= vec_next;
            data_reg <= fmt_data(color_reg, cfg.pixel_format);
        end
    end

    assign row_off = {2'b00, prod_reg} << cfg.pixel_format;

    assign busy   = (state_reg != F_IDLE);
    assign q_push = (state_reg == F_PUSH) && (vec_reg != '0) && !q_full;
    assign q_vec  = vec_reg;

    // Address of pixel zero of the span, wrapping modulo 2^32
    always_comb
    begin
        q_job.addr = cfg.base_address + 32'(row_off) + (32'(x0) << cfg.pixel_format);
        q_job.data = data_reg;
        q_job.size = cfg.pixel_format;
    end

endmodule

// ===== hw/rtl/cspw_queue.sv =====
// Short first-in first-out queue between front and back end.
module cspw_queue #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] push_data,
    output logic         full,
    input  logic         pop,
    output logic [W-1:0] pop_data,
    output logic         empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [W-1:0]  mem [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [AW:0]   count_reg, count_next;

    assign full     = (count_reg == (AW+1)'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem[rd_ptr_reg];

    // Advance pointers with wrap at the depth
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store an item
    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

endmodule

// ===== hw/rtl/cspw_back.sv =====
// Back end: walks a classified span and issues one write per marked pixel.
module cspw_back #(
    parameter int SPAN_MAX = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_empty,
    input  cspw_pkg::cspw_job_t  q_job,
    input  logic [SPAN_MAX-1:0]  q_vec,
    output logic                 q_pop,
    output logic                 write_strobe,
    output logic [31:0]          write_address,
    output logic [31:0]          write_data,
    output logic [1:0]           write_size,
    output logic                 last
);
    import cspw_pkg::*;

    logic                active_reg, active_next;
    logic [SPAN_MAX-1:0] vec_reg, vec_next;
    logic [SPAN_MAX-1:0] vec_rest;
    logic [31:0]         addr_reg, addr_next;
    logic [31:0]         data_reg;
    logic [1:0]          size_reg;
    logic                strobe_reg, strobe_next;
    logic [31:0]         out_addr_reg;
    logic                last_reg, last_next;

    assign q_pop    = !active_reg && !q_empty;
    assign vec_rest = vec_reg >> 1;

    // Take a new span when idle, else advance one pixel
    always_comb
    begin
        active_next = active_reg;
        vec_next    = vec_reg;
        addr_next   = addr_reg;
        strobe_next = 1'b0;
        last_next   = 1'b0;
        if (active_reg)
        begin
            strobe_next = vec_reg[0];
            last_next   = (vec_rest == '0);
            vec_next    = vec_rest;
            addr_next   = addr_reg + (32'd1 << size_reg);
            active_next = (vec_rest != '0);
        end
        else if (!q_empty)
        begin
            active_next = 1'b1;
            vec_next    = q_vec;
            addr_next   = q_job.addr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            strobe_reg <= strobe_next;
        end
    end

    // Hold span payload and the registered write
    always_ff @(posedge clk)
    begin
        vec_reg      <= vec_next;
        addr_reg     <= addr_next;
        out_addr_reg <= addr_reg;
        last_reg     <= last_next;
        if (q_pop)
        begin
            data_reg <= q_job.data;
            size_reg <= q_job.size;
        end
    end

    assign write_strobe  = strobe_reg;
    assign write_address = out_addr_reg;
    assign write_data    = data_reg;
    assign write_size    = size_reg;
    assign last          = last_reg;

endmodule
